// File: src/dbgbs_pkg.sv
// Shared constants, types and a helper function for the detection box gate and best select.
package dbgbs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int VAL_W     = FRAC_BITS + 1;
   localparam int CLS_W     = 8;
   localparam int SUM_W     = VAL_W + 3;
   localparam int RANK_W    = VAL_W + 4;
   localparam int PROD_W    = 2 * VAL_W + 1;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int EPS_Q     = (ONE + 999) / 1000;

   localparam int NUM_CFG   = 8;
   localparam int CFG_IDX_W = $clog2(NUM_CFG);
   localparam int ADDR_W    = CFG_IDX_W + 2;
   localparam int DATA_W    = 32;

   localparam int FIFO_SLOTS = 4;
   localparam int QPTR_W     = $clog2(FIFO_SLOTS);

   localparam logic [VAL_W-1:0] RST_SCORE_MIN   = VAL_W'((3 * ONE + 5) / 10);
   localparam logic [VAL_W-1:0] RST_ASPECT_TOL  = VAL_W'((2 * ONE + 5) / 10);
   localparam logic [VAL_W-1:0] RST_CENTER_TOL  = VAL_W'((15 * ONE + 50) / 100);
   localparam logic [VAL_W-1:0] RST_BAND_LOW    = VAL_W'(ONE / 2);
   localparam logic [VAL_W-1:0] RST_BAND_HIGH   = VAL_W'((85 * ONE + 50) / 100);
   localparam logic [VAL_W-1:0] RST_HEIGHT_TGT  = VAL_W'(ONE / 2);
   localparam logic [VAL_W-1:0] RST_HEIGHT_TOL  = VAL_W'(ONE / 4);
   localparam logic [VAL_W-1:0] RST_VERT_TGT    = VAL_W'((3 * ONE) / 4);

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_SCORE_MIN,
      REG_ASPECT_TOL,
      REG_CENTER_TOL,
      REG_BAND_LOW,
      REG_BAND_HIGH,
      REG_HEIGHT_TGT,
      REG_HEIGHT_TOL,
      REG_VERT_TGT
   } reg_idx_type;

   typedef struct packed {
      logic [VAL_W-1:0] score_min;
      logic [VAL_W-1:0] aspect_tolerance;
      logic [VAL_W-1:0] center_tolerance;
      logic [VAL_W-1:0] band_low;
      logic [VAL_W-1:0] band_high;
      logic [VAL_W-1:0] height_target;
      logic [VAL_W-1:0] height_tolerance;
      logic [VAL_W-1:0] vertical_target;
   } cfg_type;

   typedef struct packed {
      logic [VAL_W-1:0] left;
      logic [VAL_W-1:0] top;
      logic [VAL_W-1:0] right;
      logic [VAL_W-1:0] bottom;
      logic [VAL_W-1:0] conf;
      logic [CLS_W-1:0] cls;
   } box_type;

   typedef struct packed {
      logic                     keep;
      logic                     frame_end;
      logic signed [RANK_W-1:0] rank;
      box_type                  box;
   } entry_type;

   function automatic logic signed [SUM_W-1:0] abs_s(input logic signed [SUM_W-1:0] v);
      abs_s = (v < 0) ? -v : v;
   endfunction

endpackage

// File: src/dbgbs_if.sv
// Stream interfaces for box transfers in and result transfers out.
interface dbgbs_req_if;
   logic                            valid;
   logic                            ready;
   logic                            present;
   logic [dbgbs_pkg::VAL_W-1:0]     box_left;
   logic [dbgbs_pkg::VAL_W-1:0]     box_top;
   logic [dbgbs_pkg::VAL_W-1:0]     box_right;
   logic [dbgbs_pkg::VAL_W-1:0]     box_bottom;
   logic [dbgbs_pkg::VAL_W-1:0]     confidence;
   logic [dbgbs_pkg::CLS_W-1:0]     class_tag;
   logic                            frame_end;

   modport source (output valid, present, box_left, box_top, box_right, box_bottom,
                   confidence, class_tag, frame_end, input ready);
   modport sink   (input valid, present, box_left, box_top, box_right, box_bottom,
                   confidence, class_tag, frame_end, output ready);
endinterface

interface dbgbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [dbgbs_pkg::VAL_W-1:0]     best_left;
   logic [dbgbs_pkg::VAL_W-1:0]     best_top;
   logic [dbgbs_pkg::VAL_W-1:0]     best_right;
   logic [dbgbs_pkg::VAL_W-1:0]     best_bottom;
   logic [dbgbs_pkg::VAL_W-1:0]     best_confidence;
   logic [dbgbs_pkg::CLS_W-1:0]     best_class;

   modport source (output valid, found, best_left, best_top, best_right, best_bottom,
                   best_confidence, best_class, input ready);
   modport sink   (input valid, found, best_left, best_top, best_right, best_bottom,
                   best_confidence, best_class, output ready);
endinterface

// File: src/dbgbs_gate.sv
// Front stage: accepts box transfers, applies the gate and computes the rank.
module dbgbs_gate (
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          present,
   input  dbgbs_pkg::box_type            box,
   input  logic                          frame_end,
   input  dbgbs_pkg::cfg_type            cfg,
   input  logic                          queue_full,
   output logic                          push,
   output dbgbs_pkg::entry_type          entry
);

   logic signed [dbgbs_pkg::SUM_W-1:0]  l, t, r, b, c;
   logic signed [dbgbs_pkg::SUM_W-1:0]  w, h, hp, dwh, adwh;
   logic signed [dbgbs_pkg::SUM_W-1:0]  cx2, adcx, cy2, adcy, adh;
   logic [dbgbs_pkg::PROD_W-1:0]        sq_lhs, sq_rhs;
   logic                                square, centred, band, sized, scored;
   logic signed [dbgbs_pkg::RANK_W-1:0] rank;

   always_comb begin
      l = dbgbs_pkg::SUM_W'(box.left);
      t = dbgbs_pkg::SUM_W'(box.top);
      r = dbgbs_pkg::SUM_W'(box.right);
      b = dbgbs_pkg::SUM_W'(box.bottom);
      c = dbgbs_pkg::SUM_W'(box.conf);

      w    = r - l;
      h    = b - t;
      hp   = (h > dbgbs_pkg::SUM_W'(dbgbs_pkg::EPS_Q)) ? h : dbgbs_pkg::SUM_W'(dbgbs_pkg::EPS_Q);
      dwh  = w - hp;
      adwh = dbgbs_pkg::abs_s(dwh);

      sq_lhs = dbgbs_pkg::PROD_W'(adwh[dbgbs_pkg::VAL_W:0]) << dbgbs_pkg::FRAC_BITS;
      sq_rhs = dbgbs_pkg::PROD_W'(cfg.aspect_tolerance) *
               dbgbs_pkg::PROD_W'(hp[dbgbs_pkg::VAL_W-1:0]);
      square = sq_lhs <= sq_rhs;

      cx2     = l + r;
      adcx    = dbgbs_pkg::abs_s(cx2 - dbgbs_pkg::SUM_W'(dbgbs_pkg::ONE));
      centred = adcx <= (dbgbs_pkg::SUM_W'(cfg.center_tolerance) <<< 1);

      cy2  = t + b;
      band = (cy2 > (dbgbs_pkg::SUM_W'(cfg.band_low) <<< 1)) &&
             (cy2 < (dbgbs_pkg::SUM_W'(cfg.band_high) <<< 1));

      adh   = dbgbs_pkg::abs_s(h - dbgbs_pkg::SUM_W'(cfg.height_target));
      sized = adh <= dbgbs_pkg::SUM_W'(cfg.height_tolerance);

      scored = box.conf > cfg.score_min;

      adcy = dbgbs_pkg::abs_s(cy2 - (dbgbs_pkg::SUM_W'(cfg.vertical_target) <<< 1));
      rank = (dbgbs_pkg::RANK_W'(c) <<< 2) - (dbgbs_pkg::RANK_W'(adcx) <<< 1)
             - dbgbs_pkg::RANK_W'(adcy);

      entry.keep      = present && square && centred && band && sized && scored;
      entry.frame_end = frame_end;
      entry.rank      = rank;
      entry.box       = box;
   end

   assign in_ready = !queue_full;
   assign push     = in_valid && !queue_full;

endmodule

// File: src/dbgbs_queue.sv
// Short queue of classified boxes between the gate and the selector.
module dbgbs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dbgbs_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output dbgbs_pkg::entry_type head
);

   dbgbs_pkg::entry_type              q_ff [dbgbs_pkg::FIFO_SLOTS];
   logic [dbgbs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dbgbs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dbgbs_pkg::QPTR_W:0]        count_ff, count_in;

   assign full  = count_ff == (dbgbs_pkg::QPTR_W+1)'(dbgbs_pkg::FIFO_SLOTS);
   assign empty = count_ff == '0;
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/dbgbs_select.sv
// Back stage: keeps the best ranked box of the frame and registers the result.
module dbgbs_select (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  dbgbs_pkg::entry_type head,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_found,
   output dbgbs_pkg::box_type   out_box
);

   logic                                have_best_ff, have_best_in;
   logic signed [dbgbs_pkg::RANK_W-1:0] kept_rank_ff, kept_rank_in;
   dbgbs_pkg::box_type                  kept_box_ff, kept_box_in;
   logic                                out_valid_ff, out_valid_in;
   logic                                out_found_ff, out_found_in;
   dbgbs_pkg::box_type                  out_box_ff, out_box_in;
   logic                                take;
   logic                                cur_have;
   dbgbs_pkg::box_type                  cur_box;

   always_comb begin
      pop  = !empty && (!head.frame_end || !out_valid_ff || out_ready);
      take = head.keep && (!have_best_ff || head.rank > kept_rank_ff);

      cur_have = have_best_ff || (pop && take);
      cur_box  = (pop && take) ? head.box : kept_box_ff;

      have_best_in = have_best_ff;
      kept_rank_in = kept_rank_ff;
      kept_box_in  = kept_box_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_found_in = out_found_ff;
      out_box_in   = out_box_ff;

      if (pop) begin
         if (take) begin
            have_best_in = 1'b1;
            kept_rank_in = head.rank;
            kept_box_in  = head.box;
         end
         if (head.frame_end) begin
            out_valid_in = 1'b1;
            out_found_in = cur_have;
            out_box_in   = cur_have ? cur_box : '0;
            have_best_in = 1'b0;
            kept_rank_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         kept_rank_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         have_best_ff <= have_best_in;
         kept_rank_ff <= kept_rank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kept_box_ff  <= kept_box_in;
      out_found_ff <= out_found_in;
      out_box_ff   <= out_box_in;
   end

   assign out_valid = out_valid_ff;
   assign out_found = out_found_ff;
   assign out_box   = out_box_ff;

endmodule

// File: src/detection_box_gate_and_best_select_top.sv
// Top level of the detection box gate and best select: register port, gate, queue and selector.
// The block takes one box transfer per clock cycle and keeps taking them while a result waits,
// until its four-entry queue fills up behind the next frame's last mark; the gate checks each
// box in the cycle it is transferred and writes it into that queue, and the selector drains the
// queue one entry per cycle into the running best, pausing only at a frame's last entry while a
// result waits. A frame's result is registered once its last-marked entry leaves the queue, and
// holds until it is taken. The user must write registers over the APB port only while the block
// is idle, which it does not enforce. Reads return the register value zero-extended to 32 bits.
module detection_box_gate_and_best_select_top (
   input  logic                           clock,
   input  logic                           reset,
   dbgbs_req_if.sink                      req,
   dbgbs_rsp_if.source                    rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [dbgbs_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [dbgbs_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [dbgbs_pkg::DATA_W-1:0]   csr_prdata,
   output logic                           csr_pready
);

   dbgbs_pkg::cfg_type       cfg_ff, cfg_in;
   dbgbs_pkg::reg_idx_type   reg_idx;
   logic [dbgbs_pkg::VAL_W-1:0] wr_val;
   logic [dbgbs_pkg::VAL_W-1:0] rd_val;
   logic                     wr_en;
   dbgbs_pkg::box_type       in_box;
   dbgbs_pkg::entry_type     push_entry, head;
   dbgbs_pkg::box_type       out_box;
   logic                     push, pop, full, empty;

   assign csr_pready = 1'b1;
   assign reg_idx    = dbgbs_pkg::reg_idx_type'(csr_paddr[dbgbs_pkg::ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wr_val     = csr_pwdata[dbgbs_pkg::VAL_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dbgbs_pkg::REG_SCORE_MIN:  cfg_in.score_min        = wr_val;
            dbgbs_pkg::REG_ASPECT_TOL: cfg_in.aspect_tolerance = wr_val;
            dbgbs_pkg::REG_CENTER_TOL: cfg_in.center_tolerance = wr_val;
            dbgbs_pkg::REG_BAND_LOW:   cfg_in.band_low         = wr_val;
            dbgbs_pkg::REG_BAND_HIGH:  cfg_in.band_high        = wr_val;
            dbgbs_pkg::REG_HEIGHT_TGT: cfg_in.height_target    = wr_val;
            dbgbs_pkg::REG_HEIGHT_TOL: cfg_in.height_tolerance = wr_val;
            dbgbs_pkg::REG_VERT_TGT:   cfg_in.vertical_target  = wr_val;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dbgbs_pkg::REG_SCORE_MIN:  rd_val = cfg_ff.score_min;
         dbgbs_pkg::REG_ASPECT_TOL: rd_val = cfg_ff.aspect_tolerance;
         dbgbs_pkg::REG_CENTER_TOL: rd_val = cfg_ff.center_tolerance;
         dbgbs_pkg::REG_BAND_LOW:   rd_val = cfg_ff.band_low;
         dbgbs_pkg::REG_BAND_HIGH:  rd_val = cfg_ff.band_high;
         dbgbs_pkg::REG_HEIGHT_TGT: rd_val = cfg_ff.height_target;
         dbgbs_pkg::REG_HEIGHT_TOL: rd_val = cfg_ff.height_tolerance;
         dbgbs_pkg::REG_VERT_TGT:   rd_val = cfg_ff.vertical_target;
         default:                   rd_val = '0;
      endcase
      csr_prdata = dbgbs_pkg::DATA_W'(rd_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_min        <= dbgbs_pkg::RST_SCORE_MIN;
         cfg_ff.aspect_tolerance <= dbgbs_pkg::RST_ASPECT_TOL;
         cfg_ff.center_tolerance <= dbgbs_pkg::RST_CENTER_TOL;
         cfg_ff.band_low         <= dbgbs_pkg::RST_BAND_LOW;
         cfg_ff.band_high        <= dbgbs_pkg::RST_BAND_HIGH;
         cfg_ff.height_target    <= dbgbs_pkg::RST_HEIGHT_TGT;
         cfg_ff.height_tolerance <= dbgbs_pkg::RST_HEIGHT_TOL;
         cfg_ff.vertical_target  <= dbgbs_pkg::RST_VERT_TGT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      in_box.left   = req.box_left;
      in_box.top    = req.box_top;
      in_box.right  = req.box_right;
      in_box.bottom = req.box_bottom;
      in_box.conf   = req.confidence;
      in_box.cls    = req.class_tag;
   end

   dbgbs_gate u_gate (
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .present    (req.present),
      .box        (in_box),
      .frame_end  (req.frame_end),
      .cfg        (cfg_ff),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   dbgbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .head       (head)
   );

   dbgbs_select u_select (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_found (rsp.found),
      .out_box   (out_box)
   );

   assign rsp.best_left       = out_box.left;
   assign rsp.best_top        = out_box.top;
   assign rsp.best_right      = out_box.right;
   assign rsp.best_bottom     = out_box.bottom;
   assign rsp.best_confidence = out_box.conf;
   assign rsp.best_class      = out_box.cls;

endmodule

// File: src/dbgbs_checker.sv
// Port-level checks on the result channel and register port, bound to the top level.
module dbgbs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [dbgbs_pkg::VAL_W-1:0] rsp_best_left,
   input logic [dbgbs_pkg::VAL_W-1:0] rsp_best_top,
   input logic [dbgbs_pkg::VAL_W-1:0] rsp_best_right,
   input logic [dbgbs_pkg::VAL_W-1:0] rsp_best_bottom,
   input logic [dbgbs_pkg::VAL_W-1:0] rsp_best_confidence,
   input logic [dbgbs_pkg::CLS_W-1:0] rsp_best_class,
   input logic                        csr_pready
);

   a_reset_clears_result: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_best_left) && $stable(rsp_best_confidence) && $stable(rsp_best_class))
      else $error("stalled result changed");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_left == '0 && rsp_best_top == '0 &&
      rsp_best_right == '0 && rsp_best_bottom == '0 && rsp_best_confidence == '0 &&
      rsp_best_class == '0)
      else $error("empty result carries a box");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind detection_box_gate_and_best_select_top dbgbs_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_found           (rsp.found),
   .rsp_best_left       (rsp.best_left),
   .rsp_best_top        (rsp.best_top),
   .rsp_best_right      (rsp.best_right),
   .rsp_best_bottom     (rsp.best_bottom),
   .rsp_best_confidence (rsp.best_confidence),
   .rsp_best_class      (rsp.best_class),
   .csr_pready          (csr_pready)
);
